/* rtl/bmnf_pkg.sv */
// Shared types and codes for the byte-map next-fit allocator.
// Holds request/result payload structs, op codes and status codes; no dependencies.
`default_nettype none

package bmnf_pkg;

    // Request kinds.
    localparam logic [1:0] KIND_RESCAN = 2'd0;
    localparam logic [1:0] KIND_SET    = 2'd1;
    localparam logic [1:0] KIND_ALLOC  = 2'd2;
    localparam logic [1:0] KIND_NOP    = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    // Configuration register map.
    localparam int         CFG_ADDR_W      = 3;
    localparam logic       REG_USED_BLOCKS = 1'b0;
    localparam logic       REG_USED_MARKER = 1'b1;

    // Datapath operations selected by the microcode.
    typedef logic [2:0] op_t;
    localparam op_t OP_IDLE    = 3'd0;
    localparam op_t OP_CLEAR   = 3'd1;
    localparam op_t OP_SCAN0   = 3'd2;
    localparam op_t OP_SCAN    = 3'd3;
    localparam op_t OP_SET     = 3'd4;
    localparam op_t OP_ALLOC   = 3'd5;
    localparam op_t OP_DELIVER = 3'd6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] unit_index;
        logic [7:0]  flag_value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] alloc_index;
    } res_t;

    // Conditions reported by the datapath to the sequencer.
    typedef struct packed {
        logic       accept;
        logic [1:0] kind;
        logic       clr_last;
        logic       scan_end;
        logic       alloc_go;
        logic       slot_free;
    } seq_flags_t;

endpackage

`default_nettype wire

/* rtl/bmnf_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module bmnf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/bmnf_seq.sv */
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on bmnf_pkg for op codes, request kinds and the flag struct.
`default_nettype none

module bmnf_seq (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire bmnf_pkg::seq_flags_t flags,
    output bmnf_pkg::op_t             op
);
    import bmnf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLR   = 3'd1;
    localparam logic [2:0] S_RSCAN = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_SET   = 3'd4;
    localparam logic [2:0] S_ALLOC = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [2:0] C_ALWAYS   = 3'd0;
    localparam logic [2:0] C_DISPATCH = 3'd1;
    localparam logic [2:0] C_CLR_LAST = 3'd2;
    localparam logic [2:0] C_SCAN_END = 3'd3;
    localparam logic [2:0] C_ALLOC_GO = 3'd4;
    localparam logic [2:0] C_SLOT     = 3'd5;

    typedef struct packed {
        op_t        op;
        logic [2:0] cond;
        logic [2:0] tgt_t;
        logic [2:0] tgt_f;
    } ucw_t;

    function automatic ucw_t ucode_rom(input logic [2:0] step);
        ucw_t w;
        unique case (step)
            S_IDLE:  w = '{OP_IDLE,    C_DISPATCH, S_IDLE, S_IDLE};
            S_CLR:   w = '{OP_CLEAR,   C_CLR_LAST, S_IDLE, S_CLR};
            S_RSCAN: w = '{OP_SCAN0,   C_ALWAYS,   S_SCAN, S_SCAN};
            S_SCAN:  w = '{OP_SCAN,    C_SCAN_END, S_DONE, S_SCAN};
            S_SET:   w = '{OP_SET,     C_ALWAYS,   S_DONE, S_DONE};
            S_ALLOC: w = '{OP_ALLOC,   C_ALLOC_GO, S_SCAN, S_DONE};
            S_DONE:  w = '{OP_DELIVER, C_SLOT,     S_IDLE, S_DONE};
            default: w = '{OP_IDLE,    C_ALWAYS,   S_IDLE, S_IDLE};
        endcase
        return w;
    endfunction

    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic [2:0] dispatch;
    logic       cond_true;
    ucw_t       ucw;

    assign ucw = ucode_rom(step_reg);
    assign op  = ucw.op;

    always_comb begin
        case (flags.kind)
            KIND_RESCAN: dispatch = S_RSCAN;
            KIND_SET:    dispatch = S_SET;
            KIND_ALLOC:  dispatch = S_ALLOC;
            default:     dispatch = S_DONE;
        endcase
    end

    always_comb begin
        unique case (ucw.cond)
            C_ALWAYS:   cond_true = 1'b1;
            C_DISPATCH: cond_true = flags.accept;
            C_CLR_LAST: cond_true = flags.clr_last;
            C_SCAN_END: cond_true = flags.scan_end;
            C_ALLOC_GO: cond_true = flags.alloc_go;
            C_SLOT:     cond_true = flags.slot_free;
            default:    cond_true = 1'b0;
        endcase
    end

    always_comb begin
        if (ucw.cond == C_DISPATCH) begin
            step_next = flags.accept ? dispatch : ucw.tgt_f;
        end else begin
            step_next = cond_true ? ucw.tgt_t : ucw.tgt_f;
        end
    end

    // Reset enters the map clearing pass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= S_CLR;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/byte_map_next_fit_allocator_top.sv */
// Byte-map next-fit allocator: top level with datapath, map RAM and APB registers.
// Depends on bmnf_pkg, bmnf_seq and bmnf_ram.
//
// Usage: requests arrive on s_valid/s_ready/s_data (kind, unit_index, flag_value);
// each request yields exactly one result on m_valid/m_ready/m_data (status,
// alloc_index). One request is worked on at a time. A finished result sits in an
// output register, so the next request is taken while that result waits.
// A set request passes through the set step, then delivery; an unused-kind request goes
// straight to delivery. An allocate with an invalid pointer, or a pointer outside the
// used blocks, passes through the allocate step, then delivery. Rescan requests and
// allocates with a valid pointer scan the map one byte per cycle through the single
// read port of the map RAM, examining at most min(used_blocks, MAX_BLOCKS) *
// ENTRIES_PER_BLOCK bytes. After reset the map is cleared one byte per cycle, all
// DEPTH bytes (4096 at the defaults); s_ready stays low during that pass while the APB
// registers are writable. If the receiver stalls with a result still held, the
// block finishes the next request and waits until the output register frees up.
// Registers: used_blocks at byte address 0, used_marker at byte address 4.
`default_nettype none

module byte_map_next_fit_allocator_top #(
    parameter int ENTRIES_PER_BLOCK = 512,
    parameter int MAX_BLOCKS        = 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire bmnf_pkg::req_t                 s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output bmnf_pkg::res_t                      m_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bmnf_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready
);
    import bmnf_pkg::*;

    localparam int DEPTH = ENTRIES_PER_BLOCK * MAX_BLOCKS;
    localparam int AW    = $clog2(DEPTH);
    localparam int OW    = $clog2(ENTRIES_PER_BLOCK);
    localparam int BW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int BCW   = $clog2(MAX_BLOCKS + 1);
    localparam int CW    = (AW + 1 > 12) ? AW + 1 : 13;

    // Configuration registers.
    logic [3:0] used_blocks_reg;
    logic [7:0] used_marker_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_blocks_reg <= 4'd8;
            used_marker_reg <= 8'd1;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_USED_MARKER) begin
                used_marker_reg <= pwdata[7:0];
            end else begin
                used_blocks_reg <= pwdata[3:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_USED_MARKER) ? {24'd0, used_marker_reg}
                                                  : {28'd0, used_blocks_reg};

    // Sequencer.
    op_t        op;
    seq_flags_t flags;

    bmnf_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .op      (op)
    );

    // Datapath state.
    req_t           req_reg;
    logic [1:0]     status_reg;
    logic [AW-1:0]  given_reg;
    logic [AW-1:0]  free_pos_reg;
    logic [BW-1:0]  free_blk_reg;
    logic           free_known_reg;
    logic [AW-1:0]  clr_addr_reg;
    logic [BW-1:0]  blk_reg;
    logic [AW-1:0]  base_reg;
    logic [OW-1:0]  off_reg;
    logic [BCW-1:0] cnt_reg;
    logic           rd_v_reg;
    logic [AW-1:0]  rd_pos_reg;
    logic [BW-1:0]  rd_blk_reg;
    logic           m_valid_reg;
    res_t           m_data_reg;

    logic [BCW-1:0] active;
    logic [CW-1:0]  limit;
    logic           unit_in_range;
    logic           free_in_range;
    logic           accept;
    logic           slot_free;
    logic           alloc_go;
    logic           hit;
    logic           exhausted;
    logic           issue;
    logic           scan_end;
    logic           blk_last;
    logic           off_last;
    logic [AW-1:0]  scan_addr;
    logic [AW-1:0]  unit_addr;
    logic [7:0]     rd_data;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [7:0]     wr_data;

    assign active = (32'(used_blocks_reg) > MAX_BLOCKS) ? BCW'(MAX_BLOCKS)
                                                        : BCW'(used_blocks_reg);
    assign limit         = CW'(active) * CW'(ENTRIES_PER_BLOCK);
    assign unit_in_range = CW'(req_reg.unit_index) < limit;
    assign free_in_range = BCW'(free_blk_reg) < active;
    assign unit_addr     = AW'(CW'(req_reg.unit_index));

    assign s_ready   = (op == OP_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign alloc_go  = free_known_reg && free_in_range;

    assign hit       = rd_v_reg && (rd_data == 8'd0);
    assign exhausted = (cnt_reg == active);
    assign issue     = !hit && !exhausted;
    assign scan_end  = hit || exhausted;
    assign blk_last  = (BCW'(blk_reg) == active - BCW'(1));
    assign off_last  = (off_reg == OW'(ENTRIES_PER_BLOCK - 1));
    assign scan_addr = base_reg + AW'(off_reg);

    assign flags = '{
        accept:    accept,
        kind:      s_data.kind,
        clr_last:  (clr_addr_reg == AW'(DEPTH - 1)),
        scan_end:  scan_end,
        alloc_go:  alloc_go,
        slot_free: slot_free
    };

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = clr_addr_reg;
        wr_data = 8'd0;
        unique case (op)
            OP_CLEAR: begin
                wr_en = 1'b1;
            end
            OP_SET: begin
                wr_en   = unit_in_range;
                wr_addr = unit_addr;
                wr_data = req_reg.flag_value;
            end
            OP_ALLOC: begin
                wr_en   = alloc_go;
                wr_addr = free_pos_reg;
                wr_data = used_marker_reg;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    bmnf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_map (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (scan_addr),
        .rdata (rd_data)
    );

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg   <= '0;
            rd_v_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            free_known_reg <= 1'b1;
            free_pos_reg   <= '0;
            free_blk_reg   <= '0;
            cnt_reg        <= '0;
        end else begin
            if (op == OP_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            rd_v_reg <= (op == OP_SCAN) && issue;

            if (op == OP_DELIVER && slot_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (op == OP_SCAN0 || (op == OP_ALLOC && alloc_go)) begin
                cnt_reg <= '0;
            end else if (op == OP_SCAN && issue && off_last) begin
                cnt_reg <= cnt_reg + BCW'(1);
            end

            if (op == OP_SCAN && scan_end) begin
                free_known_reg <= hit;
                free_pos_reg   <= hit ? rd_pos_reg : '0;
                free_blk_reg   <= hit ? rd_blk_reg : '0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg    <= s_data;
            status_reg <= ST_OK;
            given_reg  <= '0;
        end else begin
            unique case (op)
                OP_SET: begin
                    if (!unit_in_range) begin
                        status_reg <= ST_RANGE;
                    end
                end
                OP_ALLOC: begin
                    if (!free_known_reg) begin
                        status_reg <= ST_NOSPACE;
                    end else if (!free_in_range) begin
                        status_reg <= ST_RANGE;
                    end else begin
                        given_reg <= free_pos_reg;
                    end
                end
                OP_SCAN: begin
                    // Only a plain rescan reports a failed search; an allocate keeps ok.
                    if (scan_end && !hit && req_reg.kind == KIND_RESCAN) begin
                        status_reg <= ST_NOSPACE;
                    end
                end
                default: begin
                    status_reg <= status_reg;
                end
            endcase
        end

        if (op == OP_SCAN0) begin
            blk_reg  <= '0;
            base_reg <= '0;
            off_reg  <= '0;
        end else if (op == OP_ALLOC) begin
            blk_reg  <= free_blk_reg;
            base_reg <= AW'(free_blk_reg) * AW'(ENTRIES_PER_BLOCK);
            off_reg  <= '0;
        end else if (op == OP_SCAN && issue) begin
            rd_pos_reg <= scan_addr;
            rd_blk_reg <= blk_reg;
            off_reg    <= off_last ? '0 : off_reg + OW'(1);
            if (off_last) begin
                // Block done: step to the next used block, wrapping to block zero.
                if (blk_last) begin
                    blk_reg  <= '0;
                    base_reg <= '0;
                end else begin
                    blk_reg  <= blk_reg + BW'(1);
                    base_reg <= base_reg + AW'(ENTRIES_PER_BLOCK);
                end
            end
        end

        if (op == OP_DELIVER && slot_free) begin
            m_data_reg.status      <= status_reg;
            m_data_reg.alloc_index <= 12'(CW'(given_reg));
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

/* rtl/bmnf_chk.sv */
// Port-level assertions for the byte-map next-fit allocator, bound to the top level.
// Depends on bmnf_pkg and byte_map_next_fit_allocator_top.
`default_nettype none

module bmnf_chk (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_valid,
    input wire logic           s_ready,
    input wire bmnf_pkg::req_t s_data,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire bmnf_pkg::res_t m_data
);
    import bmnf_pkg::*;

    // Reset starts the clearing pass, so no request is taken right after it.
    a_reset_blocks: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("s_ready high right after reset");

    // Only one request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted on two consecutive cycles");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_OK || m_data.status == ST_NOSPACE ||
                     m_data.status == ST_RANGE))
        else $error("undefined status code");

    // A failed request never hands out a unit.
    a_fail_no_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.alloc_index == 12'd0)
        else $error("failed request returned a unit");

endmodule

bind byte_map_next_fit_allocator_top bmnf_chk u_bmnf_chk (.*);

`default_nettype wire
